### design/jtu_pkg.sv
`default_nettype none

package jtu_pkg;

	localparam int LANES = 32;
	localparam int MAX_LENGTH = 65536;
	localparam int FRACTION_BITS = 16;

	localparam int IN_W = 32;
	localparam int LV_W = 6;
	localparam int OUT_W = 17;

	localparam int CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int NUM_W = CNT_W + 1;
	localparam int DEN_W = CNT_W + 2;
	localparam int QUOT_W = FRACTION_BITS + 1;
	localparam int STEP_W = $clog2(QUOT_W + 1);

	localparam int GROUP = 8;
	localparam int GROUPS = (LANES + GROUP - 1) / GROUP;
	localparam int GSUM_W = $clog2(GROUP + 1);
	localparam int TSUM_W = $clog2(LANES + 1);

	typedef struct packed {
		logic [IN_W-1:0] first_bits;
		logic [IN_W-1:0] second_bits;
		logic [LV_W-1:0] lanes_valid;
		logic            last;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] dissimilarity;
		logic             undefined;
	} out_t;

	typedef struct packed {
		logic both;
		logic first_only;
		logic second_only;
	} lane_cls_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              valid;
		logic [QUOT_W-1:0] quot;
		logic              undef;
	} div_rsp_t;

endpackage

`default_nettype wire

### design/jtu_lane.sv
`default_nettype none

module jtu_lane
	import jtu_pkg::*;
(
	input  wire logic clk,
	input  wire logic load,
	input  wire logic en,
	input  wire logic f_bit,
	input  wire logic s_bit,
	output lane_cls_t cls_s1
);

	lane_cls_t cls_d;

	always_comb begin
		cls_d.both        = en & f_bit & s_bit;
		cls_d.first_only  = en & f_bit & ~s_bit;
		cls_d.second_only = en & ~f_bit & s_bit;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

`default_nettype wire

### design/jtu_merge.sv
`default_nettype none

module jtu_merge
	import jtu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire logic             last_s1,
	input  wire logic [LANES-1:0] both_s1,
	input  wire logic [LANES-1:0] first_only_s1,
	input  wire logic [LANES-1:0] second_only_s1,
	output div_req_t              req
);

	logic [GSUM_W-1:0] both_g_s2 [GROUPS];
	logic [GSUM_W-1:0] fo_g_s2   [GROUPS];
	logic [GSUM_W-1:0] so_g_s2   [GROUPS];
	logic [GSUM_W-1:0] both_g_d  [GROUPS];
	logic [GSUM_W-1:0] fo_g_d    [GROUPS];
	logic [GSUM_W-1:0] so_g_d    [GROUPS];
	logic              valid_s2;
	logic              last_s2;
	logic              fin_q;

	logic [CNT_W-1:0]  shared_q;
	logic [CNT_W-1:0]  first_only_q;
	logic [CNT_W-1:0]  second_only_q;
	logic [TSUM_W-1:0] both_tot;
	logic [TSUM_W-1:0] fo_tot;
	logic [TSUM_W-1:0] so_tot;
	logic [CNT_W-1:0]  min_bc;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
		input logic [TSUM_W-1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, acc} + (CNT_W + 1)'(inc);
		if (s > (CNT_W + 1)'(MAX_LENGTH)) begin
			s = (CNT_W + 1)'(MAX_LENGTH);
		end
		return s[CNT_W-1:0];
	endfunction

	// per-group popcount, at most GROUP lanes each
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			both_g_d[g] = '0;
			fo_g_d[g]   = '0;
			so_g_d[g]   = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < LANES) begin
					both_g_d[g] = both_g_d[g] + GSUM_W'(both_s1[g * GROUP + k]);
					fo_g_d[g]   = fo_g_d[g] + GSUM_W'(first_only_s1[g * GROUP + k]);
					so_g_d[g]   = so_g_d[g] + GSUM_W'(second_only_s1[g * GROUP + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			both_g_s2[g] <= both_g_d[g];
			fo_g_s2[g]   <= fo_g_d[g];
			so_g_s2[g]   <= so_g_d[g];
		end
		last_s2 <= last_s1;
	end

	always_comb begin
		both_tot = '0;
		fo_tot   = '0;
		so_tot   = '0;
		for (int g = 0; g < GROUPS; g++) begin
			both_tot = both_tot + TSUM_W'(both_g_s2[g]);
			fo_tot   = fo_tot + TSUM_W'(fo_g_s2[g]);
			so_tot   = so_tot + TSUM_W'(so_g_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			fin_q         <= 1'b0;
			shared_q      <= '0;
			first_only_q  <= '0;
			second_only_q <= '0;
		end else begin
			valid_s2 <= valid_s1;
			fin_q    <= valid_s2 & last_s2;
			if (fin_q) begin
				shared_q      <= '0;
				first_only_q  <= '0;
				second_only_q <= '0;
			end else if (valid_s2) begin
				shared_q      <= sat_add(shared_q, both_tot);
				first_only_q  <= sat_add(first_only_q, fo_tot);
				second_only_q <= sat_add(second_only_q, so_tot);
			end
		end
	end

	always_comb begin
		min_bc    = (first_only_q < second_only_q) ? first_only_q : second_only_q;
		req.valid = fin_q;
		req.num   = {min_bc, 1'b0};
		req.den   = DEN_W'(shared_q) + DEN_W'({min_bc, 1'b0});
	end

endmodule

`default_nettype wire

### design/jtu_div.sv
`default_nettype none

module jtu_div
	import jtu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	input  wire logic     ack,
	output div_rsp_t      rsp
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} state_t;

	state_t            state_q;
	logic [DEN_W-1:0]  r_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              first_q;
	logic              undef_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// first step yields the integer bit, later steps one fraction bit each
	always_comb begin
		trial = first_q ? {1'b0, r_q} : {r_q, 1'b0};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			first_q <= 1'b0;
			cnt_q   <= '0;
			undef_q <= 1'b0;
			quot_q  <= '0;
			r_q     <= '0;
			den_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						den_q   <= req.den;
						r_q     <= DEN_W'(req.num);
						quot_q  <= '0;
						cnt_q   <= STEP_W'(QUOT_W);
						first_q <= 1'b1;
						if (req.den == '0) begin
							undef_q <= 1'b1;
							state_q <= DONE;
						end else begin
							undef_q <= 1'b0;
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					quot_q  <= {quot_q[QUOT_W-2:0], ge};
					r_q     <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					first_q <= 1'b0;
					cnt_q   <= cnt_q - STEP_W'(1);
					if (cnt_q == STEP_W'(1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (ack) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.valid = state_q == DONE;
		rsp.quot  = quot_q;
		rsp.undef = undef_q;
	end

endmodule

`default_nettype wire

### design/jaccard_turnover_dissimilarity_core.sv
// Jaccard turnover dissimilarity core.
// item channel: one chunk of up to LANES aligned presence bit-pairs per
// transaction (first_bits, second_bits, lanes_valid, last). result channel:
// one transaction per vector pair, 2*min(b,c)/(a+2*min(b,c)) in Q1.16,
// truncated, with undefined set (and a zero value) when the denominator is 0.
// Chunks not marked last are taken one per cycle while no pair is pending.
// Lanes classify their bit-pair into a register, groups of eight lanes are
// counted in a second stage, and the merge stage adds the group counts into
// saturating counters. A last chunk closes the pair: the ratio comes from a
// restoring divider that makes one quotient bit per cycle; an undefined
// ratio skips the division.
// item_ready stays low from the last chunk until its result is loaded into
// the output register; that register then waits for result_ready as long as
// the receiver stalls, while the next pair's chunks are already taken.
// A result still in the divider holds item_ready low.
// Reset clears all counters, the pipeline valids and the output valid.
`default_nettype none

module jaccard_turnover_dissimilarity_core
	import jtu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire in_t  item,
	output logic      result_valid,
	input  wire logic result_ready,
	output out_t      result
);

	logic             accept;
	logic             pending_q;
	logic             valid_s1;
	logic             last_s1;
	logic [LANES-1:0] both_s1;
	logic [LANES-1:0] first_only_s1;
	logic [LANES-1:0] second_only_s1;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic             out_load;
	logic             result_valid_q;
	out_t             result_q;

	assign item_ready = !pending_q;
	assign accept     = item_valid && item_ready;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic      f_bit;
		logic      s_bit;
		lane_cls_t cls_s1;

		if (i < IN_W) begin : g_in
			assign f_bit = item.first_bits[i];
			assign s_bit = item.second_bits[i];
		end else begin : g_pad
			assign f_bit = 1'b0;
			assign s_bit = 1'b0;
		end

		jtu_lane u_lane (
			.clk    (clk),
			.load   (accept),
			.en     (item.lanes_valid > LV_W'(i)),
			.f_bit  (f_bit),
			.s_bit  (s_bit),
			.cls_s1 (cls_s1)
		);

		assign both_s1[i]        = cls_s1.both;
		assign first_only_s1[i]  = cls_s1.first_only;
		assign second_only_s1[i] = cls_s1.second_only;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	jtu_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.last_s1        (last_s1),
		.both_s1        (both_s1),
		.first_only_s1  (first_only_s1),
		.second_only_s1 (second_only_s1),
		.req            (div_req)
	);

	assign out_load = div_rsp.valid && (!result_valid_q || result_ready);

	jtu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.ack    (out_load),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				pending_q <= 1'b0;
			end else if (accept && item.last) begin
				pending_q <= 1'b1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.dissimilarity <= OUT_W'(div_rsp.quot);
			result_q.undefined     <= div_rsp.undef;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_load_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> pending_q)
		else $error("result loaded with no pair pending");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.valid |-> !item_ready)
		else $error("input open while divider holds a result");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.undefined |-> result.dissimilarity == '0)
		else $error("undefined result with nonzero value");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.valid |-> div_rsp.quot <= QUOT_W'(1) << FRACTION_BITS)
		else $error("ratio above one");

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
	import jtu_pkg::*;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_t  item;
	logic result_valid;
	logic result_ready;
	out_t result;

	out_t        expected_ratios[$];
	int unsigned pair_shared;
	int unsigned pair_first_only;
	int unsigned pair_second_only;
	int          error_count;
	int          chunks_sent;
	bit          send_idle;

	jaccard_turnover_dissimilarity_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 1_000_000);
		$display("[jaccard_turnover_dissimilarity_core] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned sat_count(input int unsigned acc, input int unsigned inc);
		return (acc + inc > MAX_LENGTH) ? MAX_LENGTH : acc + inc;
	endfunction

	function automatic in_t chunk(input logic [31:0] f, input logic [31:0] s,
		input int lv, input bit lst);
		in_t c;
		c.first_bits  = f;
		c.second_bits = s;
		c.lanes_valid = LV_W'(lv);
		c.last        = lst;
		return c;
	endfunction

	// Count one chunk into the running pair and queue the ratio on the closing chunk.
	task automatic tally_chunk(input in_t c);
		int unsigned       n;
		logic [31:0]       mask;
		logic [31:0]       f;
		logic [31:0]       s;
		longint unsigned   m;
		longint unsigned   num;
		longint unsigned   den;
		longint unsigned   q;
		out_t              r;
		n = (int'(c.lanes_valid) > LANES) ? LANES : c.lanes_valid;
		mask = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
		f = c.first_bits & mask;
		s = c.second_bits & mask;
		pair_shared      = sat_count(pair_shared, $countones(f & s));
		pair_first_only  = sat_count(pair_first_only, $countones(f & ~s));
		pair_second_only = sat_count(pair_second_only, $countones(~f & s));
		if (c.last) begin
			m = (pair_first_only < pair_second_only) ? pair_first_only : pair_second_only;
			num = 2 * m;
			den = pair_shared + num;
			r.undefined = (den == 0);
			q = (den == 0) ? 0 : (num << FRACTION_BITS) / den;
			r.dissimilarity = q[OUT_W-1:0];
			expected_ratios.push_back(r);
			pair_shared      = 0;
			pair_first_only  = 0;
			pair_second_only = 0;
		end
	endtask

	task automatic push_chunk(input in_t c);
		int n;
		n = pick_gap(send_idle);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= c;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		tally_chunk(c);
		chunks_sent++;
	endtask

	// receiver side: random stalls with calm stretches
	initial begin
		int n;
		bit calm;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		calm = 1'b0;
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm = ($urandom_range(0, 2) == 0);
			n = pick_gap(!calm);
			if (n > 0) begin
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_ratios.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction %0d/%0b",
					result.dissimilarity, result.undefined));
			end else begin
				want = expected_ratios.pop_front();
				if (result.dissimilarity !== want.dissimilarity)
					report_mismatch($sformatf("dissimilarity got %0d want %0d",
						result.dissimilarity, want.dissimilarity));
				if (result.undefined !== want.undefined)
					report_mismatch($sformatf("undefined got %0b want %0b",
						result.undefined, want.undefined));
			end
		end
	end

	task automatic test_undefined_ratio;
		push_chunk(chunk(32'h0, 32'h0, 32, 1));
		push_chunk(chunk('1, '1, 0, 1));
		push_chunk(chunk('1, 32'h0, 32, 1));
		push_chunk(chunk(32'h0, '1, 32, 1));
	endtask

	task automatic test_extremes;
		push_chunk(chunk('1, '1, 32, 1));
		push_chunk(chunk(32'hFFFF_0000, 32'h0000_FFFF, 32, 1));
		push_chunk(chunk(32'hAAAA_AAAA, 32'h5555_5555, 32, 1));
		push_chunk(chunk('1, 32'hAAAA_AAAA, 32, 1));
		push_chunk(chunk(32'hF0F0_F0F0, 32'h0FF0_0FF0, 32, 1));
	endtask

	task automatic test_lane_limits;
		push_chunk(chunk('1, 32'h0000_FFFF, 63, 1));
		push_chunk(chunk(32'h8000_0000, 32'h7FFF_FFFF, 33, 1));
		push_chunk(chunk(32'hFFFF_FFFE, 32'hFFFF_FFFD, 1, 1));
		push_chunk(chunk(32'h3, 32'h5, 3, 1));
		push_chunk(chunk(32'hC000_0001, 32'h4000_0003, 31, 1));
	endtask

	task automatic test_multi_chunk;
		push_chunk(chunk(32'h0F, 32'hF0, 8, 0));
		push_chunk(chunk(32'h0, 32'h0, 0, 0));
		push_chunk(chunk('1, '1, 32, 0));
		push_chunk(chunk(32'h1, 32'h2, 2, 1));
		push_chunk(chunk('1, 32'h0, 32, 0));
		push_chunk(chunk(32'h0, '1, 16, 1));
		push_chunk(chunk('1, '1, 32, 1));
		push_chunk(chunk(32'hFF, 32'h0F, 8, 0));
		push_chunk(chunk('1, '1, 0, 1));
	endtask

	task automatic test_random_pairs;
		int          len;
		int          style;
		int          r;
		int          lv;
		logic [31:0] f;
		logic [31:0] s;
		chunks_sent = 0;
		while (chunks_sent < 600) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			style = $urandom_range(0, 5);
			send_idle = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < len; i++) begin
				f = $urandom;
				case (style)
					1: begin
						f = f & $urandom;
						s = $urandom & $urandom;
					end
					2: begin
						f = f | $urandom;
						s = $urandom | $urandom;
					end
					3: s = f;
					4: s = ~f & $urandom;
					5: s = ~f;
					default: s = $urandom;
				endcase
				r = $urandom_range(0, 99);
				if (r < 70)
					lv = 32;
				else if (r < 90)
					lv = $urandom_range(1, 31);
				else if (r < 95)
					lv = 0;
				else
					lv = $urandom_range(33, 63);
				push_chunk(chunk(f, s, lv, i == len - 1));
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		error_count = 0;
		pair_shared = 0;
		pair_first_only = 0;
		pair_second_only = 0;
		send_idle = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_undefined_ratio();
		test_extremes();
		test_lane_limits();
		test_multi_chunk();
		test_random_pairs();

		item_valid <= 1'b0;
		waited = 0;
		while (expected_ratios.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (expected_ratios.size() != 0)
			report_mismatch($sformatf("%0d transactions never arrived", expected_ratios.size()));

		if (error_count == 0) begin
			$display("[jaccard_turnover_dissimilarity_core] OK");
		end else begin
			$display("[jaccard_turnover_dissimilarity_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

### jaccard_turnover_dissimilarity_core.f
design/jtu_pkg.sv
design/jtu_lane.sv
design/jtu_merge.sv
design/jtu_div.sv
design/jaccard_turnover_dissimilarity_core.sv
verif/tb_top.sv
